// File: design/spma_pkg.sv
// Shared types for the sparse polynomial merge-add block.
// Holds the control and status structs passed between the top level and the merge unit.
// No dependencies.
package spma_pkg;

    // Commands from the top-level sequencer to the merge unit.
    typedef struct packed {
        logic start;   // Rewind both list heads to the first entry.
        logic run;     // Merge is active; emit terms while the output slot is free.
    } merge_ctrl_t;

    // Status from the merge unit back to the sequencer.
    typedef struct packed {
        logic done;    // The final merged term is being loaded into the output register.
    } merge_stat_t;

endpackage

// File: design/spma_term_ram.sv
// Term store: a single-port-write, single-port-read synchronous memory.
// Read data is registered. No package dependencies.
module spma_term_ram #(
    parameter int DATA_BITS = 24,
    parameter int DEPTH     = 32,
    parameter int ADDR_BITS = 5
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/spma_merge.sv
// Merge unit: walks the heads of both term lists, compares exponents and sums matches.
// Owns the list indices, the memory read addresses and the output register.
// Depends on spma_pkg.
module spma_merge #(
    parameter int EXP_BITS   = 8,
    parameter int COEFF_BITS = 16,
    parameter int CNT_BITS   = 6,
    parameter int ADDR_BITS  = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spma_pkg::merge_ctrl_t         ctrl,
    output spma_pkg::merge_stat_t         stat,
    input  logic [CNT_BITS-1:0]           first_count,
    input  logic [CNT_BITS-1:0]           second_count,
    input  logic                          drop_seen,
    output logic [ADDR_BITS-1:0]          a_rd_addr,
    output logic [ADDR_BITS-1:0]          b_rd_addr,
    input  logic [EXP_BITS+COEFF_BITS-1:0] a_data,
    input  logic [EXP_BITS+COEFF_BITS-1:0] b_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [EXP_BITS-1:0]           m_sum_exponent,
    output logic signed [COEFF_BITS:0]    m_sum_coefficient,
    output logic                          m_final_term,
    output logic                          m_overflowed
);
    import spma_pkg::*;

    localparam int SUM_BITS = COEFF_BITS + 1;

    logic [CNT_BITS-1:0] i_reg, i_next, i_adv;
    logic [CNT_BITS-1:0] j_reg, j_next, j_adv;
    logic                m_valid_reg, m_valid_next;
    logic [EXP_BITS-1:0] exp_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic                final_reg;
    logic                ovf_reg;

    logic [EXP_BITS-1:0]   a_exp, b_exp, pick_exp;
    logic [COEFF_BITS-1:0] a_coef, b_coef;
    logic [SUM_BITS-1:0]   a_ext, b_ext, pick_sum;
    logic                  have_a, have_b, take_a, take_b;
    logic                  out_free, emit, final_w;

    // Unpack the registered memory words for the current list heads.
    assign a_exp  = a_data[EXP_BITS+COEFF_BITS-1:COEFF_BITS];
    assign a_coef = a_data[COEFF_BITS-1:0];
    assign b_exp  = b_data[EXP_BITS+COEFF_BITS-1:COEFF_BITS];
    assign b_coef = b_data[COEFF_BITS-1:0];

    // Head selection: the larger exponent goes first, equal exponents go together.
    always_comb begin
        have_a   = (i_reg < first_count);
        have_b   = (j_reg < second_count);
        take_a   = have_a && (!have_b || (a_exp >= b_exp));
        take_b   = have_b && (!have_a || (b_exp >= a_exp));
        a_ext    = take_a ? {a_coef[COEFF_BITS-1], a_coef} : '0;
        b_ext    = take_b ? {b_coef[COEFF_BITS-1], b_coef} : '0;
        pick_sum = a_ext + b_ext;
        pick_exp = take_a ? a_exp : b_exp;
        out_free = !m_valid_reg || m_ready;
        emit     = ctrl.run && out_free && (have_a || have_b);
        i_adv    = take_a ? i_reg + CNT_BITS'(1) : i_reg;
        j_adv    = take_b ? j_reg + CNT_BITS'(1) : j_reg;
        final_w  = (i_adv >= first_count) && (j_adv >= second_count);
    end

    // Index update; the read address follows the next index so data lines up next cycle.
    always_comb begin
        if (ctrl.start) begin
            i_next = '0;
            j_next = '0;
        end else if (emit) begin
            i_next = i_adv;
            j_next = j_adv;
        end else begin
            i_next = i_reg;
            j_next = j_reg;
        end
        a_rd_addr = i_next[ADDR_BITS-1:0];
        b_rd_addr = j_next[ADDR_BITS-1:0];
    end

    // Output slot: filled on emit, emptied on a transfer.
    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            i_reg       <= i_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (emit) begin
            exp_reg   <= pick_exp;
            sum_reg   <= pick_sum;
            final_reg <= final_w;
            ovf_reg   <= drop_seen;
        end
    end

    assign stat.done         = emit && final_w;
    assign m_valid           = m_valid_reg;
    assign m_sum_exponent    = exp_reg;
    assign m_sum_coefficient = sum_reg;
    assign m_final_term      = final_reg;
    assign m_overflowed      = ovf_reg;

endmodule

// File: design/sparse_polynomial_merge_add.sv
// Top level of the sparse polynomial merge-add block.
// Holds the load sequencer, list counts and the two term stores; uses spma_pkg,
// spma_term_ram and spma_merge.
//
//  Channel | Direction | Ports                                                   | Transfer
//  --------+-----------+---------------------------------------------------------+----------------
//  s_      | in        | s_exponent, s_coefficient, s_ends_polynomial            | s_valid&s_ready
//  m_      | out       | m_sum_exponent, m_sum_coefficient, m_final_term,        | m_valid&m_ready
//          |           | m_overflowed                                            |
//
// Loading takes one term per cycle into the store of the current list. After the
// term that closes the second polynomial, the prime state readies the memory read ports,
// then the merge emits one term per cycle, at most first_count + second_count terms.
// The registered memory read and the output register set that one-per-cycle pace;
// a low m_ready holds the merge in place. Input is refused from the closing term
// until the final merged term enters the output register.
// Reset (synchronous, active low) clears counts, flags and the sequencer; store
// contents are not cleared, since only entries written for the current pair are read.
module sparse_polynomial_merge_add #(
    parameter int MAX_TERMS  = 32,
    parameter int EXP_BITS   = 8,
    parameter int COEFF_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [EXP_BITS-1:0]        s_exponent,
    input  logic signed [COEFF_BITS-1:0] s_coefficient,
    input  logic                       s_ends_polynomial,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [EXP_BITS-1:0]        m_sum_exponent,
    output logic signed [COEFF_BITS:0] m_sum_coefficient,
    output logic                       m_final_term,
    output logic                       m_overflowed
);
    import spma_pkg::*;

    localparam int ADDR_BITS = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_TERMS + 1);
    localparam int WORD_BITS = EXP_BITS + COEFF_BITS;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] first_count_reg, first_count_next;
    logic [CNT_BITS-1:0] second_count_reg, second_count_next;
    logic                loading_second_reg, loading_second_next;
    logic                drop_seen_reg, drop_seen_next;

    logic                 accept;
    logic                 a_full, b_full, wr_a, wr_b;
    logic [WORD_BITS-1:0] wr_word, a_data, b_data;
    logic [ADDR_BITS-1:0] a_rd_addr, b_rd_addr;
    merge_ctrl_t          ctrl;
    merge_stat_t          stat;

    assign s_ready = (state_reg == ST_LOAD);
    assign accept  = s_valid && s_ready;
    assign a_full  = (first_count_reg >= CNT_BITS'(MAX_TERMS));
    assign b_full  = (second_count_reg >= CNT_BITS'(MAX_TERMS));
    assign wr_a    = accept && !loading_second_reg && !a_full;
    assign wr_b    = accept && loading_second_reg && !b_full;
    assign wr_word = {s_exponent, s_coefficient};

    // Sequencer: load both lists, prime the read ports, then merge.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept && loading_second_reg && s_ends_polynomial) begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (stat.done) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign ctrl.start = (state_reg == ST_PRIME);
    assign ctrl.run   = (state_reg == ST_MERGE);

    // Counts and flags: grow on a stored transfer, clear when the merge finishes.
    always_comb begin
        first_count_next    = first_count_reg;
        second_count_next   = second_count_reg;
        loading_second_next = loading_second_reg;
        drop_seen_next      = drop_seen_reg;
        if (stat.done) begin
            first_count_next    = '0;
            second_count_next   = '0;
            loading_second_next = 1'b0;
            drop_seen_next      = 1'b0;
        end else if (accept) begin
            if (!loading_second_reg) begin
                if (a_full) begin
                    drop_seen_next = 1'b1;
                end else begin
                    first_count_next = first_count_reg + CNT_BITS'(1);
                end
                if (s_ends_polynomial) begin
                    loading_second_next = 1'b1;
                end
            end else begin
                if (b_full) begin
                    drop_seen_next = 1'b1;
                end else begin
                    second_count_next = second_count_reg + CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_LOAD;
            first_count_reg    <= '0;
            second_count_reg   <= '0;
            loading_second_reg <= 1'b0;
            drop_seen_reg      <= 1'b0;
        end else begin
            state_reg          <= state_next;
            first_count_reg    <= first_count_next;
            second_count_reg   <= second_count_next;
            loading_second_reg <= loading_second_next;
            drop_seen_reg      <= drop_seen_next;
        end
    end

    // Term stores for the first and second polynomial.
    spma_term_ram #(
        .DATA_BITS (WORD_BITS),
        .DEPTH     (MAX_TERMS),
        .ADDR_BITS (ADDR_BITS)
    ) u_first_ram (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (first_count_reg[ADDR_BITS-1:0]),
        .wr_data (wr_word),
        .rd_addr (a_rd_addr),
        .rd_data (a_data)
    );

    spma_term_ram #(
        .DATA_BITS (WORD_BITS),
        .DEPTH     (MAX_TERMS),
        .ADDR_BITS (ADDR_BITS)
    ) u_second_ram (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (second_count_reg[ADDR_BITS-1:0]),
        .wr_data (wr_word),
        .rd_addr (b_rd_addr),
        .rd_data (b_data)
    );

    // Merge engine and output register.
    spma_merge #(
        .EXP_BITS   (EXP_BITS),
        .COEFF_BITS (COEFF_BITS),
        .CNT_BITS   (CNT_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_merge (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .stat              (stat),
        .first_count       (first_count_reg),
        .second_count      (second_count_reg),
        .drop_seen         (drop_seen_reg),
        .a_rd_addr         (a_rd_addr),
        .b_rd_addr         (b_rd_addr),
        .a_data            (a_data),
        .b_data            (b_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sum_exponent    (m_sum_exponent),
        .m_sum_coefficient (m_sum_coefficient),
        .m_final_term      (m_final_term),
        .m_overflowed      (m_overflowed)
    );

    // After the final merged term, the block is back to loading an empty first list.
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |=> (state_reg == ST_LOAD) && (first_count_reg == '0)
                      && (second_count_reg == '0) && !loading_second_reg && !drop_seen_reg)
        else $error("merge completion did not clear the list state");

    // The lists must not change while the merge is walking them.
    a_counts_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) && $past(state_reg == ST_MERGE)
        |-> $stable(first_count_reg) && $stable(second_count_reg))
        else $error("list count changed during the merge");

    // Counts never exceed the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_count_reg <= CNT_BITS'(MAX_TERMS)) && (second_count_reg <= CNT_BITS'(MAX_TERMS)))
        else $error("list count beyond store depth");

    // A merge only starts with the second list open and the first one holding a term.
    a_prime_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRIME) |-> loading_second_reg && (first_count_reg != '0))
        else $error("merge started without both lists loaded");

endmodule

// File: test/tb_sparse_polynomial_merge_add.sv
// Self-checking testbench for the sparse polynomial merge-add block.
// A scoreboard class predicts every merged term from the accepted input terms; plain tasks
// drive the input channel and an initial block drives m_ready. Depends only on sparse_polynomial_merge_add.
`timescale 1ns / 1ps

// Expected or observed merged term.
typedef struct packed {
    logic [7:0]         exponent;
    logic signed [16:0] coefficient;
    logic               final_term;
    logic               overflowed;
} merged_term_t;

// Holds a copy of both term lists and queues the merged terms they will produce.
class merge_scoreboard;
    localparam int TERM_DEPTH = 32;

    logic [7:0]         first_exp[TERM_DEPTH];
    logic signed [15:0] first_coef[TERM_DEPTH];
    logic [7:0]         second_exp[TERM_DEPTH];
    logic signed [15:0] second_coef[TERM_DEPTH];
    int unsigned        first_count;
    int unsigned        second_count;
    bit                 loading_second;
    bit                 drop_seen;
    merged_term_t       merged_terms[$];
    int unsigned        mismatches;

    function new();
        first_count    = 0;
        second_count   = 0;
        loading_second = 1'b0;
        drop_seen      = 1'b0;
        mismatches     = 0;
    endfunction

    function int unsigned pending();
        return merged_terms.size();
    endfunction

    function void queue_term(logic [7:0] e, logic signed [16:0] c);
        merged_term_t t;
        t.exponent    = e;
        t.coefficient = c;
        t.final_term  = 1'b0;
        t.overflowed  = drop_seen;
        merged_terms.push_back(t);
    endfunction

    // Called on every accepted input term; a term that closes the second polynomial
    // merges both lists head by head as stored, the larger head exponent first.
    function void note_term(logic [7:0] e, logic signed [15:0] c, logic ends);
        int unsigned        i;
        int unsigned        j;
        int unsigned        n;
        logic signed [16:0] sum;
        i = 0;
        j = 0;
        n = 0;
        if (!loading_second) begin
            if (first_count < TERM_DEPTH) begin
                first_exp[first_count]  = e;
                first_coef[first_count] = c;
                first_count++;
            end else begin
                drop_seen = 1'b1;
            end
            if (ends) loading_second = 1'b1;
            return;
        end
        if (second_count < TERM_DEPTH) begin
            second_exp[second_count]  = e;
            second_coef[second_count] = c;
            second_count++;
        end else begin
            drop_seen = 1'b1;
        end
        if (!ends) return;

        // Merge the list heads as stored, summing on equal exponents.
        while (i < first_count && j < second_count) begin
            if (first_exp[i] > second_exp[j]) begin
                queue_term(first_exp[i], first_coef[i]);
                i++;
            end else if (second_exp[j] > first_exp[i]) begin
                queue_term(second_exp[j], second_coef[j]);
                j++;
            end else begin
                sum = first_coef[i];
                sum = sum + second_coef[j];
                queue_term(first_exp[i], sum);
                i++;
                j++;
            end
            n++;
        end
        while (i < first_count) begin
            queue_term(first_exp[i], first_coef[i]);
            i++;
            n++;
        end
        while (j < second_count) begin
            queue_term(second_exp[j], second_coef[j]);
            j++;
            n++;
        end
        if (n > 0) merged_terms[merged_terms.size() - 1].final_term = 1'b1;

        first_count    = 0;
        second_count   = 0;
        loading_second = 1'b0;
        drop_seen      = 1'b0;
    endfunction

    // Called on every accepted output term.
    function void check_term(merged_term_t got);
        merged_term_t want;
        if (merged_terms.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected term: exp=%0d coef=%0d final=%0b ovf=%0b",
                         got.exponent, got.coefficient, got.final_term, got.overflowed);
            return;
        end
        want = merged_terms.pop_front();
        if (got.exponent !== want.exponent || got.coefficient !== want.coefficient ||
                got.final_term !== want.final_term || got.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch: expected exp=%0d coef=%0d final=%0b ovf=%0b",
                         want.exponent, want.coefficient, want.final_term, want.overflowed);
                $display("          got exp=%0d coef=%0d final=%0b ovf=%0b",
                         got.exponent, got.coefficient, got.final_term, got.overflowed);
            end
        end
    endfunction
endclass

module tb_sparse_polynomial_merge_add;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_exponent;
    logic signed [15:0] s_coefficient;
    logic               s_ends_polynomial;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_sum_exponent;
    logic signed [16:0] m_sum_coefficient;
    logic               m_final_term;
    logic               m_overflowed;

    merge_scoreboard    sb = new();

    // Idle percentages for the current phase, and the count of terms sent.
    int unsigned        send_idle  = 0;
    int unsigned        recv_stall = 0;
    int unsigned        terms_sent = 0;

    // Terms of the polynomial being sent, and a copy of the last first polynomial.
    logic [7:0]         poly_exp[$];
    logic signed [15:0] poly_coef[$];
    logic [7:0]         lead_exp[$];
    logic signed [15:0] lead_coef[$];

    sparse_polynomial_merge_add i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_exponent        (s_exponent),
        .s_coefficient     (s_coefficient),
        .s_ends_polynomial (s_ends_polynomial),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sum_exponent    (m_sum_exponent),
        .m_sum_coefficient (m_sum_coefficient),
        .m_final_term      (m_final_term),
        .m_overflowed      (m_overflowed)
    );

    always #10 aclk = ~aclk;

    // Sends one term, idling first as the current phase asks; valid stays high after
    // the transfer so that a following term can go out on the next cycle.
    task automatic send_term(logic [7:0] e, logic signed [15:0] c, logic ends);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_exponent        <= e;
        s_coefficient     <= c;
        s_ends_polynomial <= ends;
        do @(posedge aclk); while (!s_ready);
        sb.note_term(e, c, ends);
        terms_sent++;
    endtask

    task automatic add_term(logic [7:0] e, logic signed [15:0] c);
        poly_exp.push_back(e);
        poly_coef.push_back(c);
    endtask

    // Sends the buffered polynomial with the ending flag on its last term.
    task automatic send_poly();
        foreach (poly_exp[k])
            send_term(poly_exp[k], poly_coef[k], k == poly_exp.size() - 1);
        poly_exp.delete();
        poly_coef.delete();
    endtask

    function automatic logic signed [15:0] random_coef();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return 16'($signed($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Fills the buffer with n terms. Exponents are distinct and in decreasing order,
    // drawn from a window of the given span; a messy list may repeat and is shuffled.
    task automatic build_list(int n, int span, bit messy);
        bit [255:0] used;
        int         base;
        int         v;
        used = '0;
        if (span < n) span = n;
        base = $urandom_range(256 - span);
        while (poly_exp.size() < n) begin
            v = base + $urandom_range(span - 1);
            if (!used[v] || messy) begin
                used[v] = 1'b1;
                poly_exp.push_back(8'(v));
            end
        end
        poly_exp.rsort();
        if (messy) poly_exp.shuffle();
        foreach (poly_exp[k]) poly_coef.push_back(random_coef());
    endtask

    // Result channel: check every transfer and stall as the phase asks.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_term({m_sum_exponent, m_sum_coefficient, m_final_term, m_overflowed});
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Stimulus.
    initial begin
        int pair_no;
        int n1;
        int n2;
        int span;
        bit messy;
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_exponent        <= '0;
        s_coefficient     <= '0;
        s_ends_polynomial <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Largest exponent with largest coefficients: the positive sum limit.
        add_term(8'd255, 16'sh7fff);
        send_poly();
        add_term(8'd255, 16'sh7fff);
        send_poly();
        // Exponent zero with the most negative coefficients.
        add_term(8'd0, 16'sh8000);
        send_poly();
        add_term(8'd0, 16'sh8000);
        send_poly();
        // Matching exponents that cancel still produce zero terms.
        add_term(8'd200, 16'sd1234);
        add_term(8'd7, -16'sd1);
        send_poly();
        add_term(8'd200, -16'sd1234);
        add_term(8'd7, 16'sd1);
        send_poly();
        // Disjoint exponents that interleave.
        add_term(8'd9, 16'sd5);
        add_term(8'd3, -16'sd7);
        add_term(8'd1, 16'sd1);
        send_poly();
        add_term(8'd8, 16'sd2);
        add_term(8'd4, 16'sd0);
        add_term(8'd0, -16'sd1);
        send_poly();
        // Unsorted lists are merged head by head as stored.
        add_term(8'd3, 16'sd10);
        add_term(8'd12, 16'sd20);
        send_poly();
        add_term(8'd5, 16'sd1);
        add_term(8'd200, 16'sd2);
        send_poly();
        // Second list runs out first, leaving a tail of the first.
        add_term(8'd150, -16'sd5);
        add_term(8'd100, 16'sd6);
        add_term(8'd50, 16'sd7);
        send_poly();
        add_term(8'd250, 16'sd1);
        send_poly();

        // Random pairs; every sixth pair overflows one of the stores.
        pair_no    = 0;
        while (terms_sent < 180) begin
            case ((pair_no / 3) % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 83; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 83; end
                default: begin send_idle = 14; recv_stall = 14; end
            endcase
            n1 = $urandom_range(1, 8);
            n2 = $urandom_range(1, 8);
            if (pair_no % 6 == 3) begin
                if (pair_no % 12 == 3) n1 = $urandom_range(33, 36);
                else n2 = $urandom_range(33, 36);
            end
            // A narrow window makes equal exponents across the lists common.
            span  = $urandom_range(1) ? 16 : 256;
            messy = ($urandom_range(9) == 0);

            build_list(n1, span, messy);
            lead_exp  = poly_exp;
            lead_coef = poly_coef;
            send_poly();

            build_list(n2, span, messy);
            foreach (poly_exp[k])
                foreach (lead_exp[m])
                    if (poly_exp[k] == lead_exp[m] && $urandom_range(2) == 0)
                        poly_coef[k] = -lead_coef[m];
            send_poly();
            pair_no++;
        end

        // Drain the remaining terms, then watch for stray output.
        s_valid    <= 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
design/spma_pkg.sv
design/spma_term_ram.sv
design/spma_merge.sv
design/sparse_polynomial_merge_add.sv
test/tb_sparse_polynomial_merge_add.sv
